// ===== sv/hmf_pkg.sv =====
`timescale 1ns / 1ps

package hmf_pkg;

   localparam int LENGTH_BITS = 32;
   localparam int NAME_LEN    = 16;
   localparam int MATCH_BITS  = 5;
   localparam int RSP_LEN_BITS = 32;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_C  = 8'h43;
   localparam logic [7:0] CH_0  = 8'h30;
   localparam logic [7:0] CH_9  = 8'h39;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef logic [LENGTH_BITS-1:0] len_type;

   localparam len_type LEN_MAX = '1;

   // per-message header scan state
   typedef struct packed {
      logic [1:0]            term;
      logic [MATCH_BITS-1:0] match;
      logic                  reading;
      logic                  found;
      len_type               acc;
      logic                  sat;
   } hdr_state_type;

   localparam hdr_state_type HDR_CLEAR = '0;

   typedef struct packed {
      logic [7:0]              out_byte;
      logic                    in_header;
      logic                    header_done;
      logic [RSP_LEN_BITS-1:0] body_length;
      logic                    length_overflow;
      logic                    last_of_message;
   } rsp_type;

   typedef struct packed {
      hdr_state_type state;
      rsp_type       rsp;
      logic          done;
   } hdr_step_type;

   // "Content-Length: "
   function automatic logic [7:0] name_char(input logic [3:0] idx);
      logic [7:0] c;
      case (idx)
         4'd0:    c = 8'h43;
         4'd1:    c = 8'h6F;
         4'd2:    c = 8'h6E;
         4'd3:    c = 8'h74;
         4'd4:    c = 8'h65;
         4'd5:    c = 8'h6E;
         4'd6:    c = 8'h74;
         4'd7:    c = 8'h2D;
         4'd8:    c = 8'h4C;
         4'd9:    c = 8'h65;
         4'd10:   c = 8'h6E;
         4'd11:   c = 8'h67;
         4'd12:   c = 8'h74;
         4'd13:   c = 8'h68;
         4'd14:   c = 8'h3A;
         4'd15:   c = 8'h20;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   // one header byte: field match, digit accumulate, terminator tracking
   function automatic hdr_step_type header_step(input hdr_state_type s,
                                                input logic [7:0] b);
      hdr_step_type              r;
      logic [LENGTH_BITS+3:0]    wide;
      logic [7:0]                expected;
      r       = '0;
      r.state = s;
      wide    = '0;
      if (s.reading) begin
         if (b inside {[CH_0:CH_9]}) begin
            wide = ({4'b0, s.acc} << 3) + ({4'b0, s.acc} << 1)
                 + (LENGTH_BITS+4)'(b - CH_0);
            if (wide > {4'b0, LEN_MAX}) begin
               r.state.acc = LEN_MAX;
               r.state.sat = 1'b1;
            end else begin
               r.state.acc = wide[LENGTH_BITS-1:0];
            end
         end else begin
            r.state.reading = 1'b0;
         end
      end else if (!s.found) begin
         if (s.match < MATCH_BITS'(NAME_LEN) && b == name_char(s.match[3:0])) begin
            if (s.match == MATCH_BITS'(NAME_LEN - 1)) begin
               r.state.found   = 1'b1;
               r.state.reading = 1'b1;
               r.state.match   = '0;
            end else begin
               r.state.match = s.match + MATCH_BITS'(1);
            end
         end else begin
            r.state.match = (b == CH_C) ? MATCH_BITS'(1) : '0;
         end
      end

      r.rsp.out_byte  = b;
      r.rsp.in_header = 1'b1;
      expected = s.term[0] ? CH_LF : CH_CR;
      if (b == expected) begin
         if (s.term == 2'd3) begin
            r.done                = 1'b1;
            r.rsp.header_done     = 1'b1;
            r.rsp.body_length     = RSP_LEN_BITS'(r.state.acc);
            r.rsp.length_overflow = r.state.sat;
            r.rsp.last_of_message = (r.state.acc == '0);
         end else begin
            r.state.term = s.term + 2'd1;
         end
      end else begin
         r.state.term = (b == CH_CR) ? 2'd1 : 2'd0;
      end
      return r;
   endfunction

endpackage

// ===== sv/hmf_if.sv =====
`timescale 1ns / 1ps

interface hmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface hmf_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        in_header;
   logic        header_done;
   logic [31:0] body_length;
   logic        length_overflow;
   logic        last_of_message;

   modport source (output valid, output out_byte, output in_header, output header_done,
                   output body_length, output length_overflow, output last_of_message,
                   input ready);
   modport sink   (input valid, input out_byte, input in_header, input header_done,
                   input body_length, input length_overflow, input last_of_message,
                   output ready);
endinterface

// ===== sv/http_message_framer.sv =====
`timescale 1ns / 1ps
// with the queue empty, the first result of a req transfer is offered in the cycle after it;
// the second result of a pair, and any result queued behind others, waits for the entries ahead of it
// throughput: one byte per cycle while req_if.ready is high; a byte gives zero, one or two results
// results wait in a four-entry queue; req_if.ready is high while at most two are queued
// reset (synchronous, active high) clears the parse state and empties the queue

module http_message_framer
   import hmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   hmf_req_if.sink     req_if,
   hmf_rsp_if.source   rsp_if
);

   // parse state
   phase_type     phase_ff, phase_in;
   logic          held_cr_ff, held_cr_in;
   hdr_state_type hdr_ff, hdr_in;
   len_type       remain_ff, remain_in;

   // result queue
   rsp_type       queue_ff [4];
   logic [1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [2:0]    count_ff, count_in;

   logic          req_xfer;
   logic          rsp_xfer;
   logic [1:0]    push_cnt;
   rsp_type       res0, res1;
   hdr_step_type  step;
   hdr_state_type step_src;
   logic [7:0]    b;

   assign b        = req_if.in_byte;
   // room for the two results a byte may cause
   assign req_if.ready = (count_ff < 3'd3);
   assign req_xfer = req_if.valid && req_if.ready;
   assign rsp_xfer = rsp_if.valid && rsp_if.ready;

   // after a held cr starts the header, the scan state is fresh with one cr seen
   always_comb begin
      step_src = hdr_ff;
      if (phase_ff == PH_IDLE && held_cr_ff) begin
         step_src      = HDR_CLEAR;
         step_src.term = 2'd1;
      end
   end

   assign step = header_step(step_src, b);

   // next state and results of the accepted byte
   always_comb begin
      phase_in   = phase_ff;
      held_cr_in = held_cr_ff;
      hdr_in     = hdr_ff;
      remain_in  = remain_ff;
      push_cnt   = 2'd0;
      res0       = '0;
      res1       = '0;
      if (req_xfer) begin
         case (phase_ff)
            PH_BODY: begin
               remain_in            = remain_ff - LENGTH_BITS'(1);
               push_cnt             = 2'd1;
               res0.out_byte        = b;
               res0.last_of_message = (remain_ff == LENGTH_BITS'(1));
               if (remain_ff == LENGTH_BITS'(1)) begin
                  phase_in = PH_IDLE;
                  hdr_in   = HDR_CLEAR;
               end
            end
            PH_HEADER: begin
               push_cnt = 2'd1;
               res0     = step.rsp;
               hdr_in   = step.state;
            end
            default: begin
               // before a message: drop empty lines, hold a lone cr
               if (held_cr_ff) begin
                  held_cr_in = 1'b0;
                  if (b != CH_LF) begin
                     phase_in       = PH_HEADER;
                     push_cnt       = 2'd2;
                     res0.out_byte  = CH_CR;
                     res0.in_header = 1'b1;
                     res1           = step.rsp;
                     hdr_in         = step.state;
                  end
               end else if (b == CH_CR) begin
                  held_cr_in = 1'b1;
               end else begin
                  phase_in = PH_HEADER;
                  push_cnt = 2'd1;
                  res0     = step.rsp;
                  hdr_in   = step.state;
               end
            end
         endcase
         // end of header: go to body, or close an empty-body message
         if (phase_ff != PH_BODY && push_cnt != 2'd0 && step.done) begin
            hdr_in = HDR_CLEAR;
            if (step.state.acc == '0) begin
               phase_in = PH_IDLE;
            end else begin
               phase_in  = PH_BODY;
               remain_in = step.state.acc;
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff + 3'(push_cnt) - 3'(rsp_xfer);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         held_cr_ff <= 1'b0;
         hdr_ff     <= HDR_CLEAR;
         remain_ff  <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         phase_ff   <= phase_in;
         held_cr_ff <= held_cr_in;
         hdr_ff     <= hdr_in;
         remain_ff  <= remain_in;
         wr_ptr_ff  <= wr_ptr_ff + push_cnt;
         rd_ptr_ff  <= rd_ptr_ff + 2'(rsp_xfer);
         count_ff   <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

   assign rsp_if.valid           = (count_ff != 3'd0);
   assign rsp_if.out_byte        = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_if.in_header       = queue_ff[rd_ptr_ff].in_header;
   assign rsp_if.header_done     = queue_ff[rd_ptr_ff].header_done;
   assign rsp_if.body_length     = queue_ff[rd_ptr_ff].body_length;
   assign rsp_if.length_overflow = queue_ff[rd_ptr_ff].length_overflow;
   assign rsp_if.last_of_message = queue_ff[rd_ptr_ff].last_of_message;

endmodule
